// ===== rtl/ssp_pkg.sv =====
package ssp_pkg;

  // request opcodes
  localparam logic [1:0] OP_LOAD_NODE = 2'd0;
  localparam logic [1:0] OP_LOAD_EDGE = 2'd1;
  localparam logic [1:0] OP_RUN       = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_EDGE_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SOURCE_NODE = 2'd2;

  // fixed field widths
  localparam int OPCODE_W  = 2;
  localparam int INDEX_W   = 12;
  localparam int OFFSET_W  = 13;
  localparam int DEST_W    = 10;
  localparam int COST_W    = 16;
  localparam int OUT_DIST_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int NODE_CNT_W = 11;
  localparam int EDGE_CNT_W = 13;
  localparam int SRC_W     = 10;

  // controller to datapath commands
  typedef struct packed {
    logic load_node;
    logic load_edge;
    logic read;
    logic run_init;
    logic clr;
    logic seed;
    logic node_rd;
    logic node_first;
    logic node_last;
    logic edge_rd;
    logic edge_dist_rd;
    logic edge_sum;
    logic edge_upd;
    logic next_node;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic src_ok;
    logic multi_node;
    logic edge_more;
    logic node_last;
    logic pass_last;
  } status_t;

endpackage

// ===== rtl/ssp_ctrl.sv =====
module ssp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            opcode,
  input  ssp_pkg::status_t      status,
  output ssp_pkg::cmd_t         cmd,
  output logic                  busy
);
  import ssp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_NODE  = 4'd3;
  localparam logic [3:0] S_NODE2 = 4'd4;
  localparam logic [3:0] S_NODE3 = 4'd5;
  localparam logic [3:0] S_ECHK  = 4'd6;
  localparam logic [3:0] S_EDGE  = 4'd7;
  localparam logic [3:0] S_EDGE2 = 4'd8;
  localparam logic [3:0] S_EDGE3 = 4'd9;
  localparam logic [3:0] S_EDGE4 = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       run_r, run_nxt;
  logic       acc;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (opcode)
            OP_LOAD_NODE: cmd.load_node = 1'b1;
            OP_LOAD_EDGE: cmd.load_edge = 1'b1;
            OP_READ:      cmd.read = 1'b1;
            default: begin
              cmd.run_init = 1'b1;
              run_nxt      = 1'b1;
              state_nxt    = S_CLR;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) state_nxt = run_r ? S_SEED : S_IDLE;
      end
      S_SEED: begin
        run_nxt  = 1'b0;
        cmd.seed = 1'b1;
        state_nxt = (status.src_ok && status.multi_node) ? S_NODE : S_IDLE;
      end
      S_NODE: begin
        cmd.node_rd = 1'b1;
        state_nxt   = S_NODE2;
      end
      S_NODE2: begin
        cmd.node_first = 1'b1;
        state_nxt      = S_NODE3;
      end
      S_NODE3: begin
        cmd.node_last = 1'b1;
        state_nxt     = S_ECHK;
      end
      S_ECHK: begin
        state_nxt = status.edge_more ? S_EDGE : S_NEXT;
      end
      S_EDGE: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_EDGE2;
      end
      S_EDGE2: begin
        cmd.edge_dist_rd = 1'b1;
        state_nxt        = S_EDGE3;
      end
      S_EDGE3: begin
        cmd.edge_sum = 1'b1;
        state_nxt    = S_EDGE4;
      end
      S_EDGE4: begin
        cmd.edge_upd = 1'b1;
        state_nxt    = S_ECHK;
      end
      S_NEXT: begin
        cmd.next_node = 1'b1;
        state_nxt = (status.node_last && status.pass_last) ? S_IDLE : S_NODE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // reset sweeps the distance memory before the first request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule

// ===== rtl/ssp_datapath.sv =====
module ssp_datapath #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_EDGES  = 4096,
  parameter int DIST_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssp_pkg::cmd_t                     cmd,
  output ssp_pkg::status_t                  status,
  input  logic [ssp_pkg::INDEX_W-1:0]       in_index,
  input  logic [ssp_pkg::OFFSET_W-1:0]      in_node_offset,
  input  logic [ssp_pkg::DEST_W-1:0]        in_edge_dest,
  input  logic signed [ssp_pkg::COST_W-1:0] in_edge_cost,
  input  logic                              cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic [ssp_pkg::DEST_W-1:0]        out_node_id,
  output logic signed [ssp_pkg::OUT_DIST_W-1:0] out_distance,
  output logic                              out_reached
);
  import ssp_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = NW + 1;
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = EW + 1;
  localparam int DW  = DIST_WIDTH;

  localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

  // configuration registers
  logic [NODE_CNT_W-1:0] node_count_r;
  logic [EDGE_CNT_W-1:0] edge_count_r;
  logic [SRC_W-1:0]      source_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_CNT_W'(1);
      edge_count_r <= '0;
      source_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:  node_count_r <= cfg_data[NODE_CNT_W-1:0];
        CFG_EDGE_COUNT:  edge_count_r <= cfg_data[EDGE_CNT_W-1:0];
        CFG_SOURCE_NODE: source_r     <= cfg_data[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // counts clipped to the store depths
  logic [NCW-1:0] n_eff;
  logic [ECW-1:0] m_eff;
  assign n_eff = (32'(node_count_r) >= MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_r);
  assign m_eff = (32'(edge_count_r) >= MAX_EDGES) ? ECW'(MAX_EDGES) : ECW'(edge_count_r);

  // memories
  logic [OFFSET_W-1:0]         start_mem [MAX_NODES];
  logic [DEST_W+COST_W-1:0]    edge_mem  [MAX_EDGES];
  logic [DW:0]                 dist_mem  [MAX_NODES];

  logic [OFFSET_W-1:0]         start_q;
  logic [DEST_W+COST_W-1:0]    edge_q;
  logic [DW:0]                 q0, q1;

  // walk counters
  logic [NW-1:0]  clr_r, node_r;
  logic [NCW-1:0] pass_r;
  logic [ECW-1:0] e_r, first_r, last_r;
  logic           reached_r;
  logic signed [DW-1:0] cand_r;
  logic           dst_ok_r;

  logic [DEST_W-1:0]        e_dst;
  logic signed [COST_W-1:0] e_cost;
  assign e_dst  = edge_q[DEST_W+COST_W-1:COST_W];
  assign e_cost = edge_q[COST_W-1:0];

  // start offset memory
  logic [NW-1:0] start_addr;
  always_comb begin
    start_addr = node_r;
    if (cmd.node_first) start_addr = NW'(32'(node_r) + 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_node && (32'(in_index) < MAX_NODES))
      start_mem[NW'(in_index)] <= in_node_offset;
    if (cmd.node_rd || cmd.node_first)
      start_q <= start_mem[start_addr];
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (cmd.load_edge && (32'(in_index) < MAX_EDGES))
      edge_mem[EW'(in_index)] <= {in_edge_dest, in_edge_cost};
    if (cmd.edge_rd)
      edge_q <= edge_mem[EW'(e_r)];
  end

  // relaxation condition
  logic signed [DW-1:0] q1_dist;
  logic                 upd;
  assign q1_dist = q1[DW-1:0];
  assign upd = cmd.edge_upd && dst_ok_r && (!q1[DW] || (cand_r < q1_dist));

  // distance memory write port
  logic          dw_en;
  logic [NW-1:0] dw_addr;
  logic [DW:0]   dw_data;
  always_comb begin
    dw_en   = 1'b0;
    dw_addr = clr_r;
    dw_data = '0;
    if (cmd.clr) begin
      dw_en = 1'b1;
    end else if (cmd.seed) begin
      dw_en   = status.src_ok;
      dw_addr = NW'(source_r);
      dw_data = {1'b1, {DW{1'b0}}};
    end else if (upd) begin
      dw_en   = 1'b1;
      dw_addr = NW'(e_dst);
      dw_data = {1'b1, cand_r};
    end
  end

  logic [NW-1:0] rd0_addr;
  assign rd0_addr = cmd.read ? NW'(in_index) : node_r;

  always_ff @(posedge clk) begin
    if (dw_en) dist_mem[dw_addr] <= dw_data;
    if (cmd.read || cmd.node_rd || cmd.edge_dist_rd) q0 <= dist_mem[rd0_addr];
    if (cmd.edge_dist_rd) q1 <= dist_mem[NW'(e_dst)];
  end

  // saturating candidate distance
  logic signed [DW:0] sum;
  assign sum = $signed({q0[DW-1], q0[DW-1:0]}) + (DW+1)'(e_cost);

  logic [ECW-1:0] start_clip;
  assign start_clip = (32'(start_q) > 32'(m_eff)) ? m_eff : ECW'(start_q);

  // walk counters and per-edge registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      node_r <= '0;
      pass_r <= '0;
      e_r    <= '0;
    end else begin
      if (cmd.run_init) begin
        clr_r  <= '0;
        node_r <= '0;
        pass_r <= '0;
      end
      if (cmd.clr) clr_r <= NW'(32'(clr_r) + 1);
      if (cmd.node_last) e_r <= first_r;
      if (cmd.edge_upd) e_r <= ECW'(32'(e_r) + 1);
      if (cmd.next_node) begin
        if (status.node_last) begin
          node_r <= '0;
          pass_r <= NCW'(32'(pass_r) + 1);
        end else begin
          node_r <= NW'(32'(node_r) + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_first) begin
      reached_r <= q0[DW];
      first_r   <= start_clip;
    end
    if (cmd.node_last) last_r <= status.node_last ? m_eff : start_clip;
    if (cmd.edge_sum) begin
      dst_ok_r <= (32'(e_dst) < 32'(n_eff));
      if (sum[DW] != sum[DW-1]) cand_r <= sum[DW] ? D_MIN : D_MAX;
      else cand_r <= sum[DW-1:0];
    end
  end

  // status to the controller
  assign status.clr_last   = (clr_r == NW'(MAX_NODES - 1));
  assign status.src_ok     = (32'(source_r) < 32'(n_eff));
  assign status.multi_node = (32'(n_eff) > 1);
  assign status.edge_more  = reached_r && (e_r < last_r);
  assign status.node_last  = ((32'(node_r) + 1) == 32'(n_eff));
  assign status.pass_last  = ((32'(pass_r) + 2) >= 32'(n_eff));

  // read result, valid in the cycle after the request
  logic              out_valid_r;
  logic              in_range_r;
  logic [DEST_W-1:0] id_r;
  logic              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.read;
    if (cmd.read) begin
      id_r       <= in_index[DEST_W-1:0];
      in_range_r <= (32'(in_index) < MAX_NODES);
    end
  end

  assign hit          = in_range_r && q0[DW];
  assign out_valid    = out_valid_r;
  assign out_node_id  = id_r;
  assign out_reached  = hit;
  assign out_distance = hit ? OUT_DIST_W'($signed(q0[DW-1:0])) : '0;

endmodule

// ===== rtl/single_source_shortest_path.sv =====
// Load and read requests keep the block idle; a read result strobes the cycle after acceptance.
// A run request clears the whole distance memory, seeds the source node, then in each pass
// walks every node and each edge of every reached node, over node_count-1 passes.
// Cost is set by the single-port distance write and the sequential edge walk.
// Synchronous active-low reset; after reset the block is busy while the distance memory
// is swept. Results cannot be stalled by the receiver.
module single_source_shortest_path #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_EDGES  = 4096,
  parameter int DIST_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ssp_pkg::OPCODE_W-1:0]          in_opcode,
  input  logic [ssp_pkg::INDEX_W-1:0]           in_index,
  input  logic [ssp_pkg::OFFSET_W-1:0]          in_node_offset,
  input  logic [ssp_pkg::DEST_W-1:0]            in_edge_dest,
  input  logic signed [ssp_pkg::COST_W-1:0]     in_edge_cost,
  output logic                                  out_valid,
  output logic [ssp_pkg::DEST_W-1:0]            out_node_id,
  output logic signed [ssp_pkg::OUT_DIST_W-1:0] out_distance,
  output logic                                  out_reached,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import ssp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ssp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ssp_datapath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_index       (in_index),
    .in_node_offset (in_node_offset),
    .in_edge_dest   (in_edge_dest),
    .in_edge_cost   (in_edge_cost),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_node_id    (out_node_id),
    .out_distance   (out_distance),
    .out_reached    (out_reached)
  );

endmodule
